/* rtl/assert_macros.svh */
// Assertion macros used by the RTL module xcr_core.
// No dependencies; clock is clk and reset is rst in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/xcr_pkg.sv */
// Shared types and constants for the XMODEM checksum receiver.
// No dependencies; used by xcr_core and xmodem_checksum_receiver.
package xcr_pkg;

  localparam int BLOCK_BYTES_DEF = 128;

  localparam logic [23:0] NAK_INTERVAL_RST = 24'd2000000;

  // Protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;

  // block number XOR its complement
  localparam logic [7:0] CMPL_MASK = 8'hFF;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_NUM    = 3'd1,
    PH_CMP    = 3'd2,
    PH_DATA   = 3'd3,
    PH_SUM    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    SS_RUNNING   = 2'd0,
    SS_DONE      = 2'd1,
    SS_CANCELLED = 2'd2,
    SS_ERROR     = 2'd3
  } session_t;

  typedef enum logic [1:0] {
    BR_NONE   = 2'd0,
    BR_ACCEPT = 2'd1,
    BR_REJECT = 2'd2
  } blk_result_t;

  typedef struct packed {
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        data_valid;
    logic [7:0]  data_byte;
    logic [6:0]  data_index;
    blk_result_t block_result;
    session_t    session;
    logic [15:0] blocks_taken;
  } xcr_result_t;

endpackage

/* rtl/xcr_core.sv */
// Protocol state and per-item next-state logic of the XMODEM receiver.
// Depends on xcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module xcr_core #(
  parameter int BLOCK_BYTES = xcr_pkg::BLOCK_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                mode,
  input  logic [7:0]          rx_byte,
  input  logic [23:0]         nak_interval,
  output xcr_pkg::xcr_result_t res
);
  import xcr_pkg::*;

  localparam int IDX_W = $clog2(BLOCK_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BLOCK_BYTES - 1);

  phase_t           phase, phase_next;
  logic             has_started, has_started_next;
  logic [7:0]       expected_block, expected_block_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [IDX_W-1:0] byte_index, byte_index_next;
  logic [23:0]      tick_count, tick_count_next;
  logic [23:0]      tick_inc;
  logic [15:0]      accepted_count, accepted_count_next;
  session_t         session_state, session_state_next;
  logic [IDX_W+6:0] idx_ext;
  logic             running, is_byte, sum_ok;

  assign running  = (session_state == SS_RUNNING);
  assign is_byte  = !mode;
  assign tick_inc = tick_count + 24'd1;
  assign sum_ok   = (running_sum == rx_byte);
  assign idx_ext  = {7'd0, byte_index};

  // Next phase
  always_comb begin
    phase_next = phase;
    if (running && is_byte) begin
      unique case (phase)
        PH_HEADER: if (rx_byte == CH_SOH) phase_next = PH_NUM;
        PH_NUM:    phase_next = (rx_byte == expected_block) ? PH_CMP : PH_HEADER;
        PH_CMP:    phase_next = ((rx_byte ^ expected_block) == CMPL_MASK) ? PH_DATA
                                                                         : PH_HEADER;
        PH_DATA:   if (byte_index == LAST_IDX) phase_next = PH_SUM;
        PH_SUM:    phase_next = PH_HEADER;
        default:   phase_next = PH_HEADER;
      endcase
    end
  end

  // Datapath and reply outputs
  always_comb begin
    has_started_next    = has_started;
    expected_block_next = expected_block;
    running_sum_next    = running_sum;
    byte_index_next     = byte_index;
    tick_count_next     = tick_count;
    accepted_count_next = accepted_count;
    session_state_next  = session_state;
    res.send_valid      = 1'b0;
    res.send_byte       = 8'd0;
    res.data_valid      = 1'b0;
    res.data_byte       = 8'd0;
    res.data_index      = 7'd0;
    res.block_result    = BR_NONE;
    if (running) begin
      if (!is_byte) begin
        // NAK pacing only until the first SOH
        if (phase == PH_HEADER && !has_started) begin
          if (tick_inc >= nak_interval) begin
            tick_count_next = 24'd0;
            res.send_valid  = 1'b1;
            res.send_byte   = CH_NAK;
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end else begin
        tick_count_next = 24'd0;
        unique case (phase)
          PH_HEADER: begin
            if (rx_byte == CH_EOT) begin
              res.send_valid     = 1'b1;
              res.send_byte      = CH_ACK;
              session_state_next = SS_DONE;
            end else if (rx_byte == CH_CAN) begin
              session_state_next = SS_CANCELLED;
            end else if (rx_byte == CH_SOH) begin
              has_started_next = 1'b1;
            end else if (has_started) begin
              session_state_next = SS_ERROR;
            end
          end
          PH_NUM: begin
            if (rx_byte != expected_block) begin
              res.send_valid   = 1'b1;
              res.send_byte    = CH_NAK;
              res.block_result = BR_REJECT;
            end
          end
          PH_CMP: begin
            if ((rx_byte ^ expected_block) == CMPL_MASK) begin
              running_sum_next = 8'd0;
              byte_index_next  = '0;
            end else begin
              res.send_valid   = 1'b1;
              res.send_byte    = CH_NAK;
              res.block_result = BR_REJECT;
            end
          end
          PH_DATA: begin
            res.data_valid   = 1'b1;
            res.data_byte    = rx_byte;
            res.data_index   = idx_ext[6:0];
            running_sum_next = running_sum + rx_byte;
            byte_index_next  = (byte_index == LAST_IDX) ? '0 : byte_index + 1'b1;
          end
          default: begin
            res.send_valid = 1'b1;
            if (sum_ok) begin
              res.send_byte       = CH_ACK;
              res.block_result    = BR_ACCEPT;
              expected_block_next = expected_block + 8'd1;
              if (accepted_count != COUNT_MAX)
                accepted_count_next = accepted_count + 16'd1;
            end else begin
              res.send_byte    = CH_NAK;
              res.block_result = BR_REJECT;
            end
            running_sum_next = 8'd0;
          end
        endcase
      end
    end
    res.session      = session_state_next;
    res.blocks_taken = accepted_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      has_started    <= 1'b0;
      expected_block <= 8'd1;
      running_sum    <= 8'd0;
      byte_index     <= '0;
      tick_count     <= 24'd0;
      accepted_count <= 16'd0;
      session_state  <= SS_RUNNING;
    end else if (step) begin
      phase          <= phase_next;
      has_started    <= has_started_next;
      expected_block <= expected_block_next;
      running_sum    <= running_sum_next;
      byte_index     <= byte_index_next;
      tick_count     <= tick_count_next;
      accepted_count <= accepted_count_next;
      session_state  <= session_state_next;
    end
  end

  `ASSERT_IMPL(a_data_in_block, step && res.data_valid, phase == PH_DATA, "payload outside block")
  `ASSERT_IMPL(a_idx_in_block, byte_index != '0, phase == PH_DATA, "byte index left set")
  `ASSERT_NEXT(a_session_sticky, session_state != SS_RUNNING, session_state == $past(session_state), "ended session changed")
  `ASSERT_NEXT(a_count_on_accept, step && res.block_result == BR_ACCEPT, accepted_count == $past(accepted_count) + 16'd1 || $past(accepted_count) == COUNT_MAX, "count missed accept")

endmodule

/* rtl/xmodem_checksum_receiver.sv */
// Top level of the XMODEM receiver with the 8-bit additive checksum.
// Depends on xcr_pkg and xcr_core.
//
// Each input item is a received serial byte (s_tuser = 0) or an idle tick
// (s_tuser = 1). The block answers every item with exactly one result item
// carrying the reply byte to send (ACK/NAK), the payload byte passed through
// with its index, the block verdict, the session status and the count of
// accepted blocks. Payload bytes appear as they arrive; the consumer should
// hold them until block_result says accept. Before the first SOH, idle ticks
// pace NAK start requests every nak_interval ticks (cfg_wdata, written with
// cfg_we while idle). Throughput is one item per clock unless m_tready
// stalls; items pass the input register, then the result register, with
// the whole protocol step (byte compares, 8-bit checksum add, 24-bit
// interval compare) done combinationally in xcr_core. Back-pressure on
// m_tready stalls the input side only once both registers hold items.

module xmodem_checksum_receiver #(
  parameter int BLOCK_BYTES = xcr_pkg::BLOCK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata,     // nak_interval
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,       // [7:0] rx_byte
  input  logic        s_tuser,       // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] send_valid, [8:1] send_byte, [9] data_valid, [17:10] data_byte,
  // [24:18] data_index, [26:25] block_result, [28:27] session,
  // [44:29] blocks_taken, [47:45] zero
  output logic [47:0] m_tdata
);
  import xcr_pkg::*;

  logic [23:0] nak_reg;
  logic        in_valid;
  logic        in_mode;
  logic [7:0]  in_byte;
  logic        advance;
  logic        step;
  xcr_result_t res;

  // output slot free or being drained this cycle
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign step     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      nak_reg <= NAK_INTERVAL_RST;
    end else if (cfg_we) begin
      nak_reg <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_mode <= s_tuser;
      in_byte <= s_tdata;
    end
  end

  xcr_core #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .mode         (in_mode),
    .rx_byte      (in_byte),
    .nak_interval (nak_reg),
    .res          (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {3'd0, res.blocks_taken, res.session, res.block_result,
                  res.data_index, res.data_byte, res.data_valid,
                  res.send_byte, res.send_valid};
    end
  end

endmodule
